### rtl/gtkr_pkg.sv
// ----------------------------------------------------------------------------
// gtkr_pkg
// Shared constants, types and keyword table for the geometry type keyword
// recognizer.
// ----------------------------------------------------------------------------
package gtkr_pkg;

  localparam int MAX_TOKEN_CHARS = 20;
  localparam int NUM_BASE        = 8;
  localparam int NUM_KW          = 32;
  localparam int BASE_MAX        = 18;
  localparam int CODE_W          = 3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // suffix codes, keyword index = {type_code, suffix}
  localparam logic [1:0] SFX_NONE = 2'd0;
  localparam logic [1:0] SFX_Z    = 2'd1;
  localparam logic [1:0] SFX_M    = 2'd2;
  localparam logic [1:0] SFX_ZM   = 2'd3;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic       wr;
    logic       clr;
    logic [7:0] chr;
  } gtkr_ctl_t;

  // fixed keyword column seen by one cell position
  typedef struct packed {
    logic [NUM_KW-1:0][7:0] chr;  // keyword byte at this position
    logic [NUM_KW-1:0]      has;  // keyword is longer than this position
    logic [NUM_KW-1:0]      fin;  // keyword ends at this position
  } gtkr_col_t;

  // base names indexed by type code, right-justified
  function automatic logic [8*BASE_MAX-1:0] base_str(int b);
    logic [8*BASE_MAX-1:0] s;
    case (b)
      0:       s = "GEOMETRY";
      1:       s = "POINT";
      2:       s = "LINESTRING";
      3:       s = "POLYGON";
      4:       s = "MULTIPOINT";
      5:       s = "MULTILINESTRING";
      6:       s = "MULTIPOLYGON";
      7:       s = "GEOMETRYCOLLECTION";
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic int base_len(int b);
    int n;
    case (b)
      0:       n = 8;
      1:       n = 5;
      2:       n = 10;
      3:       n = 7;
      4:       n = 10;
      5:       n = 15;
      6:       n = 12;
      7:       n = 18;
      default: n = 0;
    endcase
    return n;
  endfunction

  function automatic int kw_len(int k);
    int n;
    int s;
    n = base_len(k >> 2);
    s = k & 3;
    if (s == int'(SFX_ZM)) n = n + 2;
    else if (s != int'(SFX_NONE)) n = n + 1;
    return n;
  endfunction

  function automatic logic [7:0] kw_char(int k, int i);
    logic [8*BASE_MAX-1:0] s;
    logic [7:0]            c;
    int                    bl;
    int                    sfx;
    s   = base_str(k >> 2);
    bl  = base_len(k >> 2);
    sfx = k & 3;
    c   = '0;
    if (i < bl) begin
      c = s[8*(bl-1-i) +: 8];
    end else if (sfx == int'(SFX_Z)) begin
      c = CHAR_Z;
    end else if (sfx == int'(SFX_M)) begin
      c = CHAR_M;
    end else if (sfx == int'(SFX_ZM)) begin
      c = (i == bl) ? CHAR_Z : CHAR_M;
    end
    return c;
  endfunction

  function automatic gtkr_col_t gen_col(int i);
    gtkr_col_t col;
    for (int k = 0; k < NUM_KW; k++) begin
      col.chr[k] = kw_char(k, i);
      col.has[k] = (i < kw_len(k));
      col.fin[k] = (kw_len(k) == i + 1);
    end
    return col;
  endfunction

endpackage

### rtl/geometry_type_keyword_recognizer_core.sv
// ----------------------------------------------------------------------------
// geometry_type_keyword_recognizer_core
// Trims and upper-cases a streamed type name and matches it against the 32
// geometry type keywords, one result word per string.
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata from bit 0)                      notes
// s_axis   in   tdata[7:0] char_code, tlast = is_last          one byte a word
// m_axis   out  tdata[0] matched, [3:1] type_code,             one word per
//               [4] has_z, [5] has_m                           string
//
// One byte is taken every cycle while s_tready is high; the result of a
// string appears in the cycle after its last byte, from the output register.
// The chain of position cells compares each byte against all keywords in
// the cycle it arrives.
// Reset clears the fill flags and the trim state; no sweep is needed.
// s_tready drops only while a result waits and m_tready is low.
// ----------------------------------------------------------------------------
module geometry_type_keyword_recognizer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_code
  input  logic       s_tlast,   // is_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // matched, type_code[2:0], has_z, has_m
);
  import gtkr_pkg::*;

  logic              accept;
  logic              is_space;
  logic [7:0]        chr_fold;
  logic              pending;
  logic              invalid;
  logic              pending_next;
  logic              invalid_next;
  logic              full;
  logic              wr;
  gtkr_ctl_t         ctl;

  logic [MAX_TOKEN_CHARS-1:0]             cell_filled;
  logic [MAX_TOKEN_CHARS-1:0]             cell_filled_now;
  logic [MAX_TOKEN_CHARS-1:0][NUM_KW-1:0] cell_pfx;
  logic [MAX_TOKEN_CHARS-1:0][NUM_KW-1:0] cell_hit;
  logic [NUM_KW-1:0]                      hit_all;

  assign accept   = s_tvalid & s_tready;
  assign is_space = (s_tdata == CHAR_SPACE);
  assign chr_fold = (s_tdata inside {[8'h61:8'h7A]}) ? (s_tdata - CASE_DELTA) : s_tdata;
  assign full     = cell_filled[MAX_TOKEN_CHARS-1];

  always_comb begin
    pending_next = pending;
    invalid_next = invalid;
    wr           = 1'b0;
    if (accept) begin
      if (is_space) begin
        if (cell_filled[0]) pending_next = 1'b1;
      end else if (!invalid) begin
        if (pending || full) begin
          invalid_next = 1'b1;   // inner space or overlong token
        end else begin
          wr = 1'b1;
        end
      end
    end
  end

  assign ctl.wr  = wr;
  assign ctl.clr = accept & s_tlast;
  assign ctl.chr = chr_fold;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      pending <= 1'b0;
      invalid <= 1'b0;
    end else begin
      pending <= pending_next;
      invalid <= invalid_next;
    end
  end

  for (genvar g = 0; g < MAX_TOKEN_CHARS; g++) begin : g_cell
    localparam gtkr_col_t COL = gen_col(g);
    logic              prev_filled;
    logic [NUM_KW-1:0] prev_pfx;
    logic              next_filled_now;

    if (g == 0) begin : g_first
      assign prev_filled = 1'b1;
      assign prev_pfx    = '1;
    end else begin : g_inner
      assign prev_filled = cell_filled[g-1];
      assign prev_pfx    = cell_pfx[g-1];
    end

    if (g == MAX_TOKEN_CHARS-1) begin : g_last
      assign next_filled_now = 1'b0;
    end else begin : g_mid
      assign next_filled_now = cell_filled_now[g+1];
    end

    gtkr_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .ctl             (ctl),
      .col             (COL),
      .prev_filled     (prev_filled),
      .prev_pfx        (prev_pfx),
      .next_filled_now (next_filled_now),
      .filled          (cell_filled[g]),
      .pfx             (cell_pfx[g]),
      .filled_now      (cell_filled_now[g]),
      .hit             (cell_hit[g])
    );
  end

  always_comb begin
    hit_all = '0;
    for (int i = 0; i < MAX_TOKEN_CHARS; i++) begin
      hit_all = hit_all | cell_hit[i];
    end
  end

  gtkr_result u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (ctl.clr),
    .invalid  (invalid_next),
    .hit      (hit_all),
    .free     (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### rtl/gtkr_cell.sv
// ----------------------------------------------------------------------------
// gtkr_cell
// One token position: stores whether it holds a byte and which keywords
// still match up to and including it; passes both to the next position.
// ----------------------------------------------------------------------------
module gtkr_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  gtkr_pkg::gtkr_ctl_t       ctl,
  input  gtkr_pkg::gtkr_col_t       col,
  input  logic                      prev_filled,
  input  logic [gtkr_pkg::NUM_KW-1:0] prev_pfx,
  input  logic                      next_filled_now,
  output logic                      filled,
  output logic [gtkr_pkg::NUM_KW-1:0] pfx,
  output logic                      filled_now,
  output logic [gtkr_pkg::NUM_KW-1:0] hit
);
  import gtkr_pkg::*;

  logic              wr_here;
  logic              end_now;
  logic [NUM_KW-1:0] cmp;
  logic [NUM_KW-1:0] pfx_now;

  assign wr_here = ctl.wr & prev_filled & ~filled;

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      cmp[k] = col.has[k] & (ctl.chr == col.chr[k]);
    end
  end

  assign filled_now = filled | wr_here;
  assign pfx_now    = wr_here ? (prev_pfx & cmp) : pfx;
  // last stored position once this word is taken in
  assign end_now    = filled_now & ~next_filled_now;
  assign hit        = pfx_now & col.fin & {NUM_KW{end_now}};

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      filled <= 1'b0;
    end else begin
      filled <= filled_now;
    end
    pfx <= pfx_now;
  end

endmodule

### rtl/gtkr_result.sv
// ----------------------------------------------------------------------------
// gtkr_result
// Encodes the keyword hit vector and holds the result word until the
// downstream side takes it.
// ----------------------------------------------------------------------------
module gtkr_result (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        invalid,
  input  logic [gtkr_pkg::NUM_KW-1:0] hit,
  output logic                        free,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata   // matched, type_code[2:0], has_z, has_m
);
  import gtkr_pkg::*;

  logic              matched_next;
  logic [CODE_W-1:0] code_next;
  logic [1:0]        sfx_next;
  logic [4:0]        kidx;

  always_comb begin
    code_next = '0;
    sfx_next  = SFX_NONE;
    kidx      = '0;
    // at most one keyword can hit
    for (int k = 0; k < NUM_KW; k++) begin
      kidx = 5'(k);
      if (hit[k]) begin
        code_next = code_next | kidx[4:2];
        sfx_next  = sfx_next | kidx[1:0];
      end
    end
    matched_next = ~invalid & (|hit);
    if (!matched_next) begin
      code_next = '0;
      sfx_next  = SFX_NONE;
    end
  end

  assign free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load) begin
      m_tdata <= {2'b00, sfx_next[1], sfx_next[0], code_next, matched_next};
    end
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the geometry type keyword recognizer. Type-name
// strings go in one byte per word. An internal model trims, folds case and
// looks up each string, and every result word is checked against it. The
// run covers clean keywords in mixed case, padded and malformed tokens, raw
// byte noise, random sender gaps, receiver stalls and one long output
// hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gtkr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 1050;

  typedef enum logic [2:0] {
    TC_GEOMETRY, TC_POINT, TC_LINESTRING, TC_POLYGON,
    TC_MULTIPOINT, TC_MULTILINESTRING, TC_MULTIPOLYGON, TC_COLLECTION
  } geom_code_e;

  typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_e;

  typedef struct packed {
    logic       hit;
    geom_code_e code;
    logic       z;
    logic       m;
  } type_result_t;

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;  // char_code
  logic       s_tlast  = 1'b0;   // is_last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // matched, type_code[2:0], has_z, has_m, pad

  geometry_type_keyword_recognizer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // token tracker state
  logic [7:0] tok_buf [MAX_TOKEN_CHARS];
  int         tok_len = 0;
  bit         tok_gap = 0;
  bit         tok_bad = 0;

  type_result_t expected_types[$];
  logic [7:0]   word_q[$];

  int       errors        = 0;
  int       cycles        = 0;
  int       bytes_sent    = 0;
  int       strings_sent  = 0;
  int       hits_expected = 0;
  int       results_seen  = 0;
  int       stall_cycles  = 0;
  int       burst_left    = 0;
  bit       tx_gaps       = 0;
  rx_mode_e rx_mode       = RX_ALWAYS;
  logic [15:0] rx_pat     = 16'hA5C3;
  int       hold_req      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (s_tvalid && !s_tready && !rst) stall_cycles <= stall_cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_types.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic string base_name(geom_code_e c);
    case (c)
      TC_GEOMETRY:        return "GEOMETRY";
      TC_POINT:           return "POINT";
      TC_LINESTRING:      return "LINESTRING";
      TC_POLYGON:         return "POLYGON";
      TC_MULTIPOINT:      return "MULTIPOINT";
      TC_MULTILINESTRING: return "MULTILINESTRING";
      TC_MULTIPOLYGON:    return "MULTIPOLYGON";
      default:            return "GEOMETRYCOLLECTION";
    endcase
  endfunction

  function automatic type_result_t lookup_token();
    type_result_t r;
    string        nm;
    int           bl;
    int           rest;
    bit           same;
    r = '0;
    if (tok_bad || tok_len == 0) return r;
    for (int k = 0; k < NUM_BASE; k++) begin
      nm = base_name(geom_code_e'(k));
      bl = nm.len();
      if (bl > tok_len) continue;
      same = 1;
      for (int i = 0; i < bl; i++)
        if (tok_buf[i] != nm[i]) same = 0;
      if (!same) continue;
      rest = tok_len - bl;
      r.code = geom_code_e'(k);
      if (rest == 0) begin
        r.hit = 1;
      end else if (rest == 1 && tok_buf[bl] == CHAR_Z) begin
        r.hit = 1;
        r.z = 1;
      end else if (rest == 1 && tok_buf[bl] == CHAR_M) begin
        r.hit = 1;
        r.m = 1;
      end else if (rest == 2 && tok_buf[bl] == CHAR_Z && tok_buf[bl+1] == CHAR_M) begin
        r.hit = 1;
        r.z = 1;
        r.m = 1;
      end
      if (r.hit) return r;
      r = '0;
    end
    return r;
  endfunction

  // update the token tracker with one accepted byte
  task automatic absorb_char(input logic [7:0] c, input logic last);
    logic [7:0]   u;
    type_result_t r;
    u = c;
    if (c == CHAR_SPACE) begin
      if (tok_len != 0) tok_gap = 1;
    end else if (!tok_bad) begin
      if (tok_gap || tok_len >= MAX_TOKEN_CHARS) begin
        tok_bad = 1;
      end else begin
        if (c >= "a" && c <= "z") u = c - CASE_DELTA;
        tok_buf[tok_len] = u;
        tok_len++;
      end
    end
    if (last) begin
      r = lookup_token();
      expected_types.push_back(r);
      if (r.hit) hits_expected++;
      tok_len = 0;
      tok_gap = 0;
      tok_bad = 0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  initial begin : result_check
    logic [7:0]   got;
    type_result_t want;
    forever begin
      @(negedge clk);
      // both sides high here means the word moves at the next rising edge
      if (!rst && m_tvalid === 1'b1 && m_tready) begin
        got = m_tdata;
        if (expected_types.size() == 0) begin
          report_mismatch("unexpected word", int'(got), 0);
        end else begin
          want = expected_types.pop_front();
          if (got[0] !== want.hit)
            report_mismatch("matched", int'(got[0]), int'(want.hit));
          if (got[3:1] !== want.code)
            report_mismatch("type_code", int'(got[3:1]), int'(want.code));
          if (got[4] !== want.z) report_mismatch("has_z", int'(got[4]), int'(want.z));
          if (got[5] !== want.m) report_mismatch("has_m", int'(got[5]), int'(want.m));
          if (got[7:6] !== 2'b00) report_mismatch("pad bits", int'(got[7:6]), 0);
        end
        results_seen++;
      end
    end
  end

  initial begin : rx_side
    int n;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        m_tready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        case (rx_mode)
          RX_ALWAYS:  m_tready <= 1'b1;
          RX_PATTERN: begin
            m_tready <= rx_pat[0];
            rx_pat = {rx_pat[0], rx_pat[15:1]};
          end
          default:    m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // called at a rising edge; returns at the edge where the word was taken
  task automatic send_word(input logic [7:0] c, input logic last);
    int gap;
    if (tx_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    absorb_char(c, last);
    bytes_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < word_q.size(); i++)
      send_word(word_q[i], i == word_q.size() - 1);
    if (word_q.size() != 0) strings_sent++;
    word_q.delete();
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) word_q.push_back(s[i]);
  endtask

  task automatic put_keyword(int k);
    string      nm;
    logic [7:0] c;
    int         sfx;
    nm  = base_name(geom_code_e'(k >> 2));
    sfx = k & 3;
    for (int i = 0; i < nm.len(); i++) word_q.push_back(nm[i]);
    if (sfx == int'(SFX_Z) || sfx == int'(SFX_ZM)) word_q.push_back(CHAR_Z);
    if (sfx == int'(SFX_M) || sfx == int'(SFX_ZM)) word_q.push_back(CHAR_M);
    for (int i = 0; i < word_q.size(); i++) begin
      c = word_q[i];
      if ($urandom_range(0, 1)) word_q[i] = c + CASE_DELTA;
    end
  endtask

  task automatic set_idling();
    tx_gaps = ($urandom_range(0, 2) != 0);
    rx_mode = rx_mode_e'($urandom_range(0, 2));
    rx_pat  = 16'($urandom_range(1, 16'hFFFF));
    burst_left = 0;
  endtask

  // stop driving and let every pending result come out
  task automatic drain();
    s_tvalid <= 1'b0;
    rx_mode = RX_ALWAYS;
    while (expected_types.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_string();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    word_q.delete();
    if (kind < 85) begin
      put_keyword($urandom_range(0, NUM_KW - 1));
      if (kind >= 55 && kind < 63) begin
        word_q[$urandom_range(0, word_q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind >= 63 && kind < 70) begin
        word_q.insert($urandom_range(1, word_q.size() - 1), CHAR_SPACE);
      end else if (kind >= 70 && kind < 77) begin
        // pad past the longest keyword, or exactly to the buffer size
        n = $urandom_range(0, 1) ? MAX_TOKEN_CHARS : $urandom_range(21, 26);
        while (word_q.size() < n) word_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
      end else if (kind >= 77) begin
        if ($urandom_range(0, 1)) word_q.pop_back();
        else word_q.push_back($urandom_range(0, 1) ? CHAR_Z : CHAR_M);
      end
      n = $urandom_range(0, 2);
      repeat (n) word_q.push_front(CHAR_SPACE);
      n = $urandom_range(0, 2);
      repeat (n) word_q.push_back(CHAR_SPACE);
    end else if (kind < 95) begin
      n = $urandom_range(1, 24);
      repeat (n) word_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) word_q.push_back(CHAR_SPACE);
    end
    send_string();
  endtask

  task automatic test_keyword_basics();
    put_text("Point");
    send_string();
    put_text(" polygonZm  ");
    send_string();
    put_text("GEOMETRYCOLLECTIONZM");
    send_string();
    drain();
  endtask

  task automatic test_malformed_tokens();
    put_text("X Y");          // inner space
    send_string();
    put_text(" ");            // nothing but a space
    send_string();
    word_q.push_back(8'h00);  // zero byte
    send_string();
    word_q.push_back(8'hFF);
    send_string();
    put_text("POINT");
    word_q.push_back(8'hF4);  // high byte is not folded
    send_string();
    put_text("GEOMETRYCOLLECTIONZMM");  // one past the buffer
    send_string();
    drain();
  endtask

  task automatic test_output_stall();
    tx_gaps = 0;
    hold_req = 300;
    repeat (20) begin
      put_keyword($urandom_range(0, NUM_KW - 1));
      send_string();
    end
    drain();
  endtask

  task automatic test_random_stream(int target);
    int n;
    n = 0;
    while (bytes_sent < target) begin
      if (n % 15 == 0) set_idling();
      random_string();
      n++;
    end
    drain();
  endtask

  initial begin : main_seq
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_keyword_basics();
    test_malformed_tokens();
    test_output_stall();
    test_random_stream(ITEM_TARGET);
    if (expected_types.size() != 0)
      report_mismatch("results never arrived", expected_types.size(), 0);
    $display("Sent %0d bytes in %0d strings; %0d results checked, %0d keyword hits.",
             bytes_sent, strings_sent, results_seen, hits_expected);
    $display("Input was held off for %0d cycles by output back-pressure.", stall_cycles);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
